[hw/rtl/tlv16_record_deframer_core_defines.svh]
// ----------------------------------------------------------------------------
// TLV16 record deframer assertion macros
// Shared concurrent assertion wrappers, clocked on aclk, off during reset.
// ----------------------------------------------------------------------------
`ifndef TLV16_RECORD_DEFRAMER_CORE_DEFINES_SVH
`define TLV16_RECORD_DEFRAMER_CORE_DEFINES_SVH

// same-cycle implication
`define TLVDF_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define TLVDF_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |=> (cons)) else $error(msg);

`endif

[hw/rtl/tlvdf_pkg.sv]
// ----------------------------------------------------------------------------
// TLV16 record deframer package
// Result word type, result kind codes and the push bundle between stages.
// ----------------------------------------------------------------------------
package tlvdf_pkg;

    localparam int QUEUE_DEPTH = 4;

    localparam logic [2:0] KIND_HEADER  = 3'd0;
    localparam logic [2:0] KIND_PAYLOAD = 3'd1;
    localparam logic [2:0] KIND_DONE    = 3'd2;
    localparam logic [2:0] KIND_TRUNC   = 3'd3;
    localparam logic [2:0] KIND_EMPTY   = 3'd4;

    typedef struct packed {
        logic [2:0]  kind;
        logic [7:0]  record_type;
        logic [15:0] record_length;
        logic [7:0]  payload_byte;
        logic        last_of_record;
        logic        last_of_run;
    } result_t;

    typedef struct packed {
        logic [1:0] count;
        result_t    first;
        result_t    second;
    } push_t;

endpackage

[hw/rtl/tlv16_record_deframer_core.sv]
// ----------------------------------------------------------------------------
// TLV16 record deframer core
// Splits a byte buffer into type / 16-bit LE length / payload records.
// ----------------------------------------------------------------------------
// One input byte is accepted per clock while s_ready is high. A byte yields one
// result word, or none for the type and low length bytes; a byte flagged
// end_of_buffer also yields a status word, so the final byte of a buffer can
// put two words out, which leave one at a time. Words wait in an output queue of QDEPTH
// entries; s_ready is high while at least two entries are free and low during
// reset. With a ready consumer the input runs at one byte per cycle without a
// stall: the queue absorbs the one extra word per buffer, which drains while
// the next bytes come in. A word is presented on m_valid the cycle after its
// byte is accepted when no older word waits ahead of it. Status words are
// done, truncated or empty list; discard the whole list on an error status.
module tlv16_record_deframer_core #(
    parameter int QDEPTH = tlvdf_pkg::QUEUE_DEPTH
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_data_byte,
    input  logic        s_end_of_buffer,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_kind,
    output logic [7:0]  m_record_type,
    output logic [15:0] m_record_length,
    output logic [7:0]  m_payload_byte,
    output logic        m_last_of_record,
    output logic        m_last_of_run
);
    import tlvdf_pkg::*;

    push_t   push;
    result_t out_word;
    logic    space_ok;
    logic    in_fire;

    assign s_ready = space_ok & aresetn;
    assign in_fire = s_valid & s_ready;

    tlvdf_parser u_parser (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .in_fire       (in_fire),
        .data_byte     (s_data_byte),
        .end_of_buffer (s_end_of_buffer),
        .push          (push)
    );

    tlvdf_out_queue #(
        .QDEPTH (QDEPTH)
    ) u_out_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .space_ok  (space_ok),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_word  (out_word)
    );

    assign m_kind           = out_word.kind;
    assign m_record_type    = out_word.record_type;
    assign m_record_length  = out_word.record_length;
    assign m_payload_byte   = out_word.payload_byte;
    assign m_last_of_record = out_word.last_of_record;
    assign m_last_of_run    = out_word.last_of_run;

endmodule

[hw/rtl/tlvdf_parser.sv]
// ----------------------------------------------------------------------------
// TLV16 record deframer parser
// Tracks record phase and counters; builds up to two result words per byte.
// ----------------------------------------------------------------------------
module tlvdf_parser (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_fire,
    input  logic [7:0]       data_byte,
    input  logic             end_of_buffer,
    output tlvdf_pkg::push_t push
);
    import tlvdf_pkg::*;

    `include "tlv16_record_deframer_core_defines.svh"

    localparam logic [1:0] PH_TYPE   = 2'd0;
    localparam logic [1:0] PH_LEN_LO = 2'd1;
    localparam logic [1:0] PH_LEN_HI = 2'd2;
    localparam logic [1:0] PH_DATA   = 2'd3;

    logic [1:0]  phase_reg,       phase_next;
    logic [7:0]  held_type_reg,   held_type_next;
    logic [15:0] held_length_reg, held_length_next;
    logic [15:0] bytes_left_reg,  bytes_left_next;
    logic        seen_reg,        seen_next;

    logic        complete;
    logic        has_item;
    logic [15:0] left_dec;
    logic [2:0]  item_kind;
    logic [7:0]  item_payload;
    logic [1:0]  phase_mid;
    logic        seen_mid;
    logic [2:0]  status_kind;
    result_t     item_word;
    result_t     status_word;

    always_comb begin
        held_type_next   = held_type_reg;
        held_length_next = held_length_reg;
        bytes_left_next  = bytes_left_reg;
        phase_mid        = phase_reg;
        complete         = 1'b0;
        has_item         = 1'b0;
        item_kind        = KIND_HEADER;
        item_payload     = 8'h00;
        left_dec         = (bytes_left_reg != 16'd0) ? bytes_left_reg - 16'd1
                                                     : bytes_left_reg;
        unique case (phase_reg)
            PH_TYPE: begin
                held_type_next = data_byte;
                phase_mid      = PH_LEN_LO;
            end
            PH_LEN_LO: begin
                held_length_next = {8'h00, data_byte};
                phase_mid        = PH_LEN_HI;
            end
            PH_LEN_HI: begin
                held_length_next = {data_byte, held_length_reg[7:0]};
                bytes_left_next  = held_length_next;
                complete         = (held_length_next == 16'd0);
                has_item         = 1'b1;
                phase_mid        = complete ? PH_TYPE : PH_DATA;
            end
            default: begin
                bytes_left_next = left_dec;
                complete        = (left_dec == 16'd0);
                has_item        = 1'b1;
                item_kind       = KIND_PAYLOAD;
                item_payload    = data_byte;
                if (complete) begin
                    phase_mid = PH_TYPE;
                end
            end
        endcase
        seen_mid = seen_reg | complete;

        priority if (phase_mid != PH_TYPE) begin
            status_kind = KIND_TRUNC;
        end else if (seen_mid) begin
            status_kind = KIND_DONE;
        end else begin
            status_kind = KIND_EMPTY;
        end

        phase_next = phase_mid;
        seen_next  = seen_mid;
        if (end_of_buffer) begin
            phase_next      = PH_TYPE;
            bytes_left_next = 16'd0;
            seen_next       = 1'b0;
        end

        item_word.kind           = item_kind;
        item_word.record_type    = held_type_next;
        item_word.record_length  = held_length_next;
        item_word.payload_byte   = item_payload;
        item_word.last_of_record = complete;
        item_word.last_of_run    = ~end_of_buffer;

        status_word.kind           = status_kind;
        status_word.record_type    = held_type_next;
        status_word.record_length  = held_length_next;
        status_word.payload_byte   = 8'h00;
        status_word.last_of_record = 1'b0;
        status_word.last_of_run    = 1'b1;

        push.first  = has_item ? item_word : status_word;
        push.second = status_word;
        if (!in_fire) begin
            push.count = 2'd0;
        end else begin
            push.count = {1'b0, has_item} + {1'b0, end_of_buffer};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg       <= PH_TYPE;
            held_type_reg   <= 8'h00;
            held_length_reg <= 16'h0000;
            bytes_left_reg  <= 16'h0000;
            seen_reg        <= 1'b0;
        end else if (in_fire) begin
            phase_reg       <= phase_next;
            held_type_reg   <= held_type_next;
            held_length_reg <= held_length_next;
            bytes_left_reg  <= bytes_left_next;
            seen_reg        <= seen_next;
        end
    end

    `TLVDF_ASSERT_SAME(a_data_has_bytes, phase_reg == PH_DATA, bytes_left_reg != 16'd0,
        "payload phase with no bytes left")
    `TLVDF_ASSERT_NEXT(a_end_resets, in_fire && end_of_buffer,
        phase_reg == PH_TYPE && bytes_left_reg == 16'd0 && !seen_reg,
        "state not cleared after end of buffer")
    `TLVDF_ASSERT_SAME(a_two_only_at_end, push.count == 2'd2, end_of_buffer && in_fire,
        "two words pushed without end of buffer")

endmodule

[hw/rtl/tlvdf_out_queue.sv]
// ----------------------------------------------------------------------------
// TLV16 record deframer output queue
// Takes up to two words per cycle, sends one per cycle while out_ready is set.
// ----------------------------------------------------------------------------
module tlvdf_out_queue #(
    parameter int QDEPTH = tlvdf_pkg::QUEUE_DEPTH
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  tlvdf_pkg::push_t   push,
    output logic               space_ok,
    output logic               out_valid,
    input  logic               out_ready,
    output tlvdf_pkg::result_t out_word
);
    import tlvdf_pkg::*;

    `include "tlv16_record_deframer_core_defines.svh"

    localparam int PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int CW = $clog2(QDEPTH + 1);
    localparam logic [PW-1:0] LAST_IDX = PW'(QDEPTH - 1);
    localparam logic [CW-1:0] FILL_LIMIT = CW'(QDEPTH - 2);

    result_t       mem [QDEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg,  count_next;
    logic [PW-1:0] wr_ptr_inc;
    logic          pop;

    function automatic logic [PW-1:0] wrap_inc(input logic [PW-1:0] p);
        return (p == LAST_IDX) ? '0 : p + PW'(1);
    endfunction

    assign pop        = out_valid & out_ready;
    assign out_valid  = (count_reg != '0);
    assign out_word   = mem[rd_ptr_reg];
    assign space_ok   = (count_reg <= FILL_LIMIT);
    assign wr_ptr_inc = wrap_inc(wr_ptr_reg);

    always_comb begin
        rd_ptr_next = pop ? wrap_inc(rd_ptr_reg) : rd_ptr_reg;
        unique case (push.count)
            2'd0:    wr_ptr_next = wr_ptr_reg;
            2'd1:    wr_ptr_next = wr_ptr_inc;
            default: wr_ptr_next = wrap_inc(wr_ptr_inc);
        endcase
        count_next = count_reg + CW'(push.count) - CW'(pop);
    end

    always_ff @(posedge aclk) begin
        if (push.count != 2'd0) begin
            mem[wr_ptr_reg] <= push.first;
        end
        if (push.count == 2'd2) begin
            mem[wr_ptr_inc] <= push.second;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    `TLVDF_ASSERT_SAME(a_no_overflow, 1'b1, count_reg <= CW'(QDEPTH),
        "queue count above depth")
    `TLVDF_ASSERT_NEXT(a_pair_counted, push.count == 2'd2 && !pop,
        count_reg == $past(count_reg) + CW'(2), "pair push not counted")
    `TLVDF_ASSERT_SAME(a_push_has_room, push.count != 2'd0, space_ok,
        "word pushed into a full queue")

endmodule

[tb/tb_tlv16_record_deframer_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// TLV16 record deframer core testbench
// Feeds byte buffers into the deframer: a short directed table first, then
// random well-formed, truncated and noise buffers, with random stalls on both
// sides. Every output word is compared field by field with a typed word or a
// bench-side model of the type / length / payload parser.
// ----------------------------------------------------------------------------
module tb_tlv16_record_deframer_core;
    import tlvdf_pkg::*;

    localparam int RANDOM_ITEMS = 1350;
    localparam int STALL_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 16;

    typedef enum logic [1:0] {
        WANT_TYPE,
        WANT_LEN_LO,
        WANT_LEN_HI,
        IN_PAYLOAD
    } parse_phase_t;

    typedef struct {
        logic [7:0] data;
        logic       eob;
        int         n_typed;
        result_t    w0;
        result_t    w1;
    } stim_row_t;

    logic        aclk            = 1'b0;
    logic        aresetn         = 1'b0;
    logic        s_valid         = 1'b0;
    logic [7:0]  s_data_byte     = 8'h00;
    logic        s_end_of_buffer = 1'b0;
    logic        m_ready         = 1'b0;
    logic        s_ready;
    logic        m_valid;
    logic [2:0]  m_kind;
    logic [7:0]  m_record_type;
    logic [15:0] m_record_length;
    logic [7:0]  m_payload_byte;
    logic        m_last_of_record;
    logic        m_last_of_run;

    parse_phase_t phase_q = WANT_TYPE;
    logic [7:0]   type_q  = 8'h00;
    logic [15:0]  len_q   = 16'h0000;
    logic [15:0]  left_q  = 16'h0000;
    logic         seen_q  = 1'b0;

    result_t   expected_words[$];
    stim_row_t stim_table[$];
    int        fail_count   = 0;
    int        idle_pct     = 12;
    int        stall_cycles = 0;
    int        items_sent   = 0;

    tlv16_record_deframer_core uut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_data_byte      (s_data_byte),
        .s_end_of_buffer  (s_end_of_buffer),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_kind           (m_kind),
        .m_record_type    (m_record_type),
        .m_record_length  (m_record_length),
        .m_payload_byte   (m_payload_byte),
        .m_last_of_record (m_last_of_record),
        .m_last_of_run    (m_last_of_run)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    function automatic result_t word(input logic [2:0] kind, input logic [7:0] rtype,
                                     input logic [15:0] rlen, input logic [7:0] pay,
                                     input logic lor, input logic lrun);
        result_t r;
        r.kind           = kind;
        r.record_type    = rtype;
        r.record_length  = rlen;
        r.payload_byte   = pay;
        r.last_of_record = lor;
        r.last_of_run    = lrun;
        return r;
    endfunction

    // Advance the parser by one byte; returns the number of words it yields.
    function automatic int deframe_byte(input logic [7:0] d, input logic eob,
                                        output result_t w0, output result_t w1);
        int         n;
        logic       rec_done;
        logic [2:0] status;
        n        = 0;
        rec_done = 1'b0;
        w0       = '0;
        w1       = '0;
        case (phase_q)
            WANT_TYPE: begin
                type_q  = d;
                phase_q = WANT_LEN_LO;
            end
            WANT_LEN_LO: begin
                len_q   = {8'h00, d};
                phase_q = WANT_LEN_HI;
            end
            WANT_LEN_HI: begin
                len_q[15:8] = d;
                left_q      = len_q;
                rec_done    = (len_q == 16'h0000);
                w0          = word(KIND_HEADER, type_q, len_q, 8'h00, rec_done, 1'b0);
                n           = 1;
                phase_q     = rec_done ? WANT_TYPE : IN_PAYLOAD;
            end
            default: begin
                if (left_q != 16'h0000)
                    left_q = left_q - 16'h0001;
                rec_done = (left_q == 16'h0000);
                w0       = word(KIND_PAYLOAD, type_q, len_q, d, rec_done, 1'b0);
                n        = 1;
                if (rec_done)
                    phase_q = WANT_TYPE;
            end
        endcase
        if (rec_done)
            seen_q = 1'b1;
        if (eob) begin
            if (phase_q != WANT_TYPE)
                status = KIND_TRUNC;
            else if (seen_q)
                status = KIND_DONE;
            else
                status = KIND_EMPTY;
            if (n == 0)
                w0 = word(status, type_q, len_q, 8'h00, 1'b0, 1'b0);
            else
                w1 = word(status, type_q, len_q, 8'h00, 1'b0, 1'b0);
            n++;
            phase_q = WANT_TYPE;
            left_q  = 16'h0000;
            seen_q  = 1'b0;
        end
        if (n == 1)
            w0.last_of_run = 1'b1;
        else if (n == 2)
            w1.last_of_run = 1'b1;
        return n;
    endfunction

    function automatic void add_row(input logic [7:0] d, input logic eob, input int n_typed,
                                    input result_t w0, input result_t w1);
        stim_row_t row;
        row.data    = d;
        row.eob     = eob;
        row.n_typed = n_typed;
        row.w0      = w0;
        row.w1      = w1;
        stim_table.push_back(row);
    endfunction

    // Present one byte and hold it until accepted; typed words override the model.
    task automatic send_byte(input logic [7:0] d, input logic eob, input int n_typed,
                             input result_t t0, input result_t t1);
        result_t p0;
        result_t p1;
        int      n;
        while ($urandom_range(99) < idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid         <= 1'b1;
        s_data_byte     <= d;
        s_end_of_buffer <= eob;
        do @(posedge aclk); while (!s_ready);
        items_sent++;
        n = deframe_byte(d, eob, p0, p1);
        if (n_typed > 0) begin
            p0 = t0;
            p1 = t1;
            n  = n_typed;
        end
        if (n > 0)
            expected_words.push_back(p0);
        if (n > 1)
            expected_words.push_back(p1);
    endtask

    task automatic send_random_buffer();
        logic [7:0] frame_bytes[$];
        int         style;
        int         n_rec;
        int         len;
        int         cut;
        style = $urandom_range(99);
        if (style < 8) begin
            repeat ($urandom_range(1, 6)) frame_bytes.push_back(8'($urandom_range(255)));
        end else begin
            n_rec = $urandom_range(1, 4);
            for (int r = 0; r < n_rec; r++) begin
                len = ($urandom_range(99) < 6) ? $urandom_range(0, 65535) : $urandom_range(0, 8);
                frame_bytes.push_back(8'($urandom_range(255)));
                frame_bytes.push_back(len[7:0]);
                frame_bytes.push_back(len[15:8]);
                if (len > 40) begin
                    repeat ($urandom_range(0, 5))
                        frame_bytes.push_back(8'($urandom_range(255)));
                    break;
                end
                repeat (len) frame_bytes.push_back(8'($urandom_range(255)));
            end
            if (style >= 85) begin
                cut = $urandom_range(1, frame_bytes.size());
                while (frame_bytes.size() > cut)
                    void'(frame_bytes.pop_back());
            end
        end
        foreach (frame_bytes[i])
            send_byte(frame_bytes[i], i == frame_bytes.size() - 1, 0, '0, '0);
    endtask

    task automatic drain_expected();
        s_valid <= 1'b0;
        do @(posedge aclk); while (expected_words.size() != 0);
    endtask

    function automatic void check_field(input string name, input logic [15:0] exp_v,
                                        input logic [15:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
            fail_count++;
        end
    endfunction

    always @(posedge aclk) begin
        result_t exp_w;
        if (aresetn && m_valid && m_ready) begin
            if (expected_words.size() == 0) begin
                $error("output word with none expected: kind %0d", m_kind);
                fail_count++;
            end else begin
                exp_w = expected_words.pop_front();
                check_field("kind", 16'(exp_w.kind), 16'(m_kind));
                check_field("record_type", 16'(exp_w.record_type), 16'(m_record_type));
                check_field("record_length", exp_w.record_length, m_record_length);
                check_field("payload_byte", 16'(exp_w.payload_byte), 16'(m_payload_byte));
                check_field("last_of_record", 16'(exp_w.last_of_record),
                            16'(m_last_of_record));
                check_field("last_of_run", 16'(exp_w.last_of_run), 16'(m_last_of_run));
            end
        end
        m_ready <= ($urandom_range(99) >= idle_pct);
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial begin
        // header cut short right after reset
        add_row(8'hFF, 1'b1, 1, word(KIND_TRUNC, 8'hFF, 16'h0000, 8'h00, 1'b0, 1'b1), '0);
        // zero-length record ends the buffer
        add_row(8'h00, 1'b0, 0, '0, '0);
        add_row(8'h00, 1'b0, 0, '0, '0);
        add_row(8'h00, 1'b1, 2, word(KIND_HEADER, 8'h00, 16'h0000, 8'h00, 1'b1, 1'b0),
                word(KIND_DONE, 8'h00, 16'h0000, 8'h00, 1'b0, 1'b1));
        // buffer ends on the high length byte of a full-size record
        add_row(8'hAB, 1'b0, 0, '0, '0);
        add_row(8'hFF, 1'b0, 0, '0, '0);
        add_row(8'hFF, 1'b1, 2, word(KIND_HEADER, 8'hAB, 16'hFFFF, 8'h00, 1'b0, 1'b0),
                word(KIND_TRUNC, 8'hAB, 16'hFFFF, 8'h00, 1'b0, 1'b1));
        // two records, the second ends the buffer exactly
        add_row(8'h12, 1'b0, 0, '0, '0);
        add_row(8'h02, 1'b0, 0, '0, '0);
        add_row(8'h00, 1'b0, 0, '0, '0);
        add_row(8'h55, 1'b0, 0, '0, '0);
        add_row(8'hAA, 1'b0, 0, '0, '0);
        add_row(8'h34, 1'b0, 0, '0, '0);
        add_row(8'h01, 1'b0, 0, '0, '0);
        add_row(8'h00, 1'b0, 0, '0, '0);
        add_row(8'hFF, 1'b1, 0, '0, '0);
        // buffer ends inside a payload
        add_row(8'h7F, 1'b0, 0, '0, '0);
        add_row(8'h03, 1'b0, 0, '0, '0);
        add_row(8'h00, 1'b0, 0, '0, '0);
        add_row(8'h00, 1'b0, 0, '0, '0);
        add_row(8'h80, 1'b1, 0, '0, '0);
        // buffer ends on the low length byte
        add_row(8'h01, 1'b0, 0, '0, '0);
        add_row(8'h05, 1'b1, 1, word(KIND_TRUNC, 8'h01, 16'h0005, 8'h00, 1'b0, 1'b1), '0);

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (stim_table[i])
            send_byte(stim_table[i].data, stim_table[i].eob, stim_table[i].n_typed,
                      stim_table[i].w0, stim_table[i].w1);
        drain_expected();

        while (items_sent < RANDOM_ITEMS) begin
            idle_pct = (items_sent >= 500 && items_sent < 800) ? 0 : 12;
            send_random_buffer();
            if (items_sent >= 1000 && items_sent < 1050)
                drain_expected();
        end

        drain_expected();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
